// ----- sv/lse_pkg.sv -----
// ----------------------------------------------------------------------------
// lse_pkg
// shared types and constants for the lifo stack engine: request and result
// layouts, operation codes, sequencer states and the ram command bundle
// ----------------------------------------------------------------------------
`default_nettype none

package lse_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH   = 3'd0,
    K_POP    = 3'd1,
    K_PEEK   = 3'd2,
    K_INVERT = 3'd3,
    K_REMOVE = 3'd4,
    K_CLEAR  = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_word;
    logic                     ok;
    logic [CW-1:0]            depth_now;
    logic                     is_empty;
    logic                     is_full;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } ram_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_INV_A,
    S_INV_B,
    S_INV_C,
    S_INV_D,
    S_RM,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- sv/lse_ram.sv -----
// ----------------------------------------------------------------------------
// lse_ram
// entry storage: one write port and one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module lse_ram (
  input  logic                         clk,
  input  lse_pkg::ram_cmd_t            cmd,
  output logic [lse_pkg::WORD_W-1:0]   rd_data
);
  import lse_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[cmd.raddr];
  end

endmodule

`default_nettype wire

// ----- sv/lifo_stack_engine.sv -----
// ----------------------------------------------------------------------------
// lifo_stack_engine
// bounded lifo stack of signed 32-bit words with push, pop, peek, invert,
// remove-by-value and clear, one result per request
// ----------------------------------------------------------------------------
// One request is worked at a time; req_stall stays high from acceptance until
// the result is loaded into the output register. All entry accesses go
// through a single ram with one write and one registered read per cycle.
// Push, clear and unknown codes go straight to the done state; pop and peek
// pass through a read state (not on an empty stack); invert runs the states
// INV_A to INV_D once per swapped pair (n/2 pairs for n entries), and
// remove_value stays in its compaction state as it reads every entry once and
// compacts the survivors in the same pass. A result waiting in the output
// register does not block acceptance of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lse_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output lse_pkg::res_t res
);
  import lse_pkg::*;

  state_t                   state, state_next;
  logic [CW-1:0]            count, count_next;
  logic signed [WORD_W-1:0] word, word_next;
  logic                     ok_flag, ok_flag_next;
  logic signed [WORD_W-1:0] rm_value, rm_value_next;
  logic [AW-1:0]            lo, lo_next;
  logic [AW-1:0]            hi, hi_next;
  logic [WORD_W-1:0]        tmp, tmp_next;
  logic [CW-1:0]            rd, rd_next;
  logic [CW-1:0]            wr, wr_next;
  logic [CW-1:0]            removed, removed_next;
  logic                     pend, pend_next;

  ram_cmd_t          cmd;
  logic [WORD_W-1:0] rd_data;
  logic [CW-1:0]     count_m1;
  logic              out_free;
  logic              inv_more;
  logic              accept;

  lse_ram u_ram (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign out_free  = !res_valid || !res_stall;
  assign count_m1  = count - CW'(1);
  // another pair remains after the current swap
  assign inv_more  = ((AW+1)'(lo) + (AW+1)'(2)) < (AW+1)'(hi);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.kind)
            K_POP, K_PEEK: state_next = (count != '0) ? S_READ : S_DONE;
            K_INVERT:      state_next = (count > CW'(1)) ? S_INV_A : S_DONE;
            K_REMOVE:      state_next = S_RM;
            default:       state_next = S_DONE;
          endcase
        end
      end
      S_READ:  state_next = S_DONE;
      S_INV_A: state_next = S_INV_B;
      S_INV_B: state_next = S_INV_C;
      S_INV_C: state_next = S_INV_D;
      S_INV_D: state_next = inv_more ? S_INV_A : S_DONE;
      S_RM:    state_next = (!pend && rd == count) ? S_DONE : S_RM;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    count_next    = count;
    word_next     = word;
    ok_flag_next  = ok_flag;
    rm_value_next = rm_value;
    lo_next       = lo;
    hi_next       = hi;
    tmp_next      = tmp;
    rd_next       = rd;
    wr_next       = wr;
    removed_next  = removed;
    pend_next     = pend;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          word_next     = '0;
          ok_flag_next  = 1'b1;
          rm_value_next = req.value;
          lo_next       = '0;
          hi_next       = count_m1[AW-1:0];
          rd_next       = '0;
          wr_next       = '0;
          removed_next  = '0;
          pend_next     = 1'b0;
          case (req.kind)
            K_PUSH: begin
              if (count < CW'(DEPTH)) begin
                cmd.we     = 1'b1;
                cmd.waddr  = count[AW-1:0];
                cmd.wdata  = req.value;
                count_next = count + CW'(1);
              end else begin
                ok_flag_next = 1'b0;
              end
            end
            K_POP: begin
              if (count != '0) begin
                cmd.raddr  = count_m1[AW-1:0];
                count_next = count_m1;
              end else begin
                ok_flag_next = 1'b0;
              end
            end
            K_PEEK: begin
              if (count != '0) begin
                cmd.raddr = count_m1[AW-1:0];
              end else begin
                ok_flag_next = 1'b0;
              end
            end
            K_INVERT, K_REMOVE: begin
            end
            K_CLEAR: begin
              count_next = '0;
            end
            default: begin
              ok_flag_next = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        word_next = rd_data;
      end
      S_INV_A: begin
        cmd.raddr = lo;
      end
      S_INV_B: begin
        tmp_next  = rd_data;
        cmd.raddr = hi;
      end
      S_INV_C: begin
        cmd.we    = 1'b1;
        cmd.waddr = lo;
        cmd.wdata = rd_data;
      end
      S_INV_D: begin
        cmd.we    = 1'b1;
        cmd.waddr = hi;
        cmd.wdata = tmp;
        lo_next   = lo + AW'(1);
        hi_next   = hi - AW'(1);
      end
      S_RM: begin
        // compare the word read last cycle, keep it at the write pointer unless it matches
        if (pend) begin
          if (rd_data == rm_value) begin
            removed_next = removed + CW'(1);
          end else begin
            cmd.we    = 1'b1;
            cmd.waddr = wr[AW-1:0];
            cmd.wdata = rd_data;
            wr_next   = wr + CW'(1);
          end
        end
        if (rd != count) begin
          cmd.raddr = rd[AW-1:0];
          rd_next   = rd + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && rd == count) begin
          count_next = wr;
          word_next  = WORD_W'(removed);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    word     <= word_next;
    ok_flag  <= ok_flag_next;
    rm_value <= rm_value_next;
    lo       <= lo_next;
    hi       <= hi_next;
    tmp      <= tmp_next;
    rd       <= rd_next;
    wr       <= wr_next;
    removed  <= removed_next;
    pend     <= pend_next;
    if (state == S_DONE && out_free) begin
      res.result_word <= word;
      res.ok          <= ok_flag;
      res.depth_now   <= count;
      res.is_empty    <= (count == '0);
      res.is_full     <= (count == CW'(DEPTH));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.kind == K_CLEAR |=> count == '0)
    else $error("clear request left entries");

  a_rm_pointers: assert property (@(posedge clk) disable iff (rst)
    state == S_RM |-> (wr <= rd && rd <= count))
    else $error("compaction pointers out of order");

  a_inv_pair: assert property (@(posedge clk) disable iff (rst)
    (state == S_INV_A || state == S_INV_B || state == S_INV_C || state == S_INV_D)
      |-> lo < hi)
    else $error("invert swap with crossed indexes");

  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_empty == (res.depth_now == '0)))
    else $error("result empty flag disagrees with depth");

endmodule

`default_nettype wire
